// ----- rtl/core/mavg_pkg.sv -----
`default_nettype none
package mavg_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int SAMPLE_W      = 16;
  localparam int LEN_W         = 5;
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last_rd;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/core/mavg_div.sv -----
`default_nettype none
module mavg_div
  import mavg_pkg::*;
#(
  parameter int SUM_W = 20
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                step,
  input  wire logic [SUM_W-1:0]    dividend,
  input  wire logic [LEN_W-1:0]    divisor,
  output logic                     last,
  output logic [SAMPLE_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(SUM_W);

  logic [LEN_W-1:0] rem;
  logic [SUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [LEN_W:0]   shifted;
  logic [LEN_W:0]   diff;
  logic             fits;

  assign shifted  = {rem, quo[SUM_W-1]};
  assign fits     = shifted >= {1'b0, divisor};
  assign diff     = shifted - {1'b0, divisor};
  assign last     = cnt == CNT_W'(SUM_W - 1);
  assign quotient = quo[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (step) begin
      rem <= fits ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/mavg_datapath.sv -----
`default_nettype none
module mavg_datapath
  import mavg_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output status_t                  st,
  input  wire logic                cfg_we,
  input  wire logic [LEN_W-1:0]    cfg_wdata,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      average
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

  logic [SAMPLE_W-1:0]     mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] vld;
  logic [LEN_W-1:0]        window_len;
  logic [LEN_W-1:0]        n_eff;
  logic [LEN_W-1:0]        n_next;
  logic [LEN_W-1:0]        cnt;
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [SAMPLE_W-1:0]     rd_data;
  logic                    rd_ok;
  logic                    rd_vld;
  logic [SUM_W-1:0]        sum;
  logic [SAMPLE_W-1:0]     quotient;
  logic                    div_last;

  // zero length reads as one, overlong saturates at the store depth
  always_comb begin
    if (window_len == '0) begin
      n_next = LEN_W'(1);
    end else if (int'(window_len) > WINDOW_DEPTH) begin
      n_next = LEN_W'(WINDOW_DEPTH);
    end else begin
      n_next = window_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_RESET;
    end else if (cfg_we) begin
      window_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wr_ptr] <= sample;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      wr_ptr <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
      if (cmd.load) begin
        vld[wr_ptr] <= 1'b1;
        wr_ptr      <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_ok <= vld[rd_ptr];
    end
  end

  // walk backward from the newest sample
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_ptr <= wr_ptr;
      cnt    <= '0;
      n_eff  <= n_next;
      sum    <= '0;
    end else begin
      if (cmd.rd_en) begin
        rd_ptr <= (rd_ptr == '0) ? PTR_LAST : rd_ptr - 1'b1;
        cnt    <= cnt + 1'b1;
      end
      if (rd_vld && rd_ok) begin
        sum <= sum + SUM_W'(rd_data);
      end
    end
  end

  mavg_div #(
    .SUM_W(SUM_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .step    (cmd.div_step),
    .dividend(sum),
    .divisor (n_eff),
    .last    (div_last),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average <= quotient;
    end
  end

  assign st.last_rd  = cnt == n_eff - 1'b1;
  assign st.div_last = div_last;
  assign st.out_busy = out_valid && !out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result overwritten before taken");

  a_no_overread: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (cnt < n_eff))
    else $error("window read past its length");

  a_sum_settled: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (!rd_vld && !cmd.rd_en))
    else $error("divide started with reads in flight");

endmodule
`default_nettype wire

// ----- rtl/core/mavg_ctrl.sv -----
`default_nettype none
module mavg_ctrl
  import mavg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        if (st.last_rd) state_next = ST_DRAIN;
      end
      ST_DRAIN:    state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV: begin
        if (st.div_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!st.out_busy) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_READ:     cmd.rd_en     = 1'b1;
      ST_DIV_INIT: cmd.div_start = 1'b1;
      ST_DIV:      cmd.div_step  = 1'b1;
      ST_FINISH:   cmd.out_load  = !st.out_busy;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/moving_average_filter.sv -----
// the input beat starts n window reads through the single memory read port,
//   n the effective window length, then an S-step bit-serial divide, with
//   S = 16 + clog2(WINDOW_DEPTH) the sum width (20 by default), then loads the result
// a new beat is accepted only in idle, once the previous result has been loaded
// reset: window reads as zero, write pointer zero, window_len 16, no result pending
`default_nettype none
module moving_average_filter
  import mavg_pkg::*;
#(
  parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [LEN_W-1:0]    cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SAMPLE_W-1:0]      average
);

  cmd_t    cmd;
  status_t st;

  mavg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  mavg_datapath #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .sample   (sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .average  (average)
  );

endmodule
`default_nettype wire
